// ===== rtl/core/caf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// caf_pkg: shared types and constants of the CPU ALU
// Operation codes, flag bit positions, the command and response beats, and
// the records that pass between the pipeline stages.
// ----------------------------------------------------------------------------
package caf_pkg;

    // Operation codes.
    localparam logic [5:0] OP_ADD   = 6'd0;
    localparam logic [5:0] OP_ADC   = 6'd1;
    localparam logic [5:0] OP_SUB   = 6'd2;
    localparam logic [5:0] OP_SBC   = 6'd3;
    localparam logic [5:0] OP_AND   = 6'd4;
    localparam logic [5:0] OP_XOR   = 6'd5;
    localparam logic [5:0] OP_OR    = 6'd6;
    localparam logic [5:0] OP_CP    = 6'd7;
    localparam logic [5:0] OP_INC   = 6'd8;
    localparam logic [5:0] OP_DEC   = 6'd9;
    localparam logic [5:0] OP_RLCA  = 6'd10;
    localparam logic [5:0] OP_RRCA  = 6'd11;
    localparam logic [5:0] OP_RLA   = 6'd12;
    localparam logic [5:0] OP_RRA   = 6'd13;
    localparam logic [5:0] OP_DAA   = 6'd14;
    localparam logic [5:0] OP_CPL   = 6'd15;
    localparam logic [5:0] OP_SCF   = 6'd16;
    localparam logic [5:0] OP_CCF   = 6'd17;
    localparam logic [5:0] OP_RLC   = 6'd18;
    localparam logic [5:0] OP_RRC   = 6'd19;
    localparam logic [5:0] OP_RL    = 6'd20;
    localparam logic [5:0] OP_RR    = 6'd21;
    localparam logic [5:0] OP_SLA   = 6'd22;
    localparam logic [5:0] OP_SRA   = 6'd23;
    localparam logic [5:0] OP_SWAP  = 6'd24;
    localparam logic [5:0] OP_SRL   = 6'd25;
    localparam logic [5:0] OP_BIT   = 6'd26;
    localparam logic [5:0] OP_RES   = 6'd27;
    localparam logic [5:0] OP_SET   = 6'd28;
    localparam logic [5:0] OP_ADD16 = 6'd29;
    localparam logic [5:0] OP_ADDSP = 6'd30;
    localparam logic [5:0] OP_INC16 = 6'd31;
    localparam logic [5:0] OP_DEC16 = 6'd32;

    // Flag bit positions.
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // Decimal adjust constants.
    localparam logic [7:0] DAA_LIMIT  = 8'h99;
    localparam logic [3:0] DAA_DIGIT  = 4'd9;
    localparam logic [7:0] DAA_ADJ_LO = 8'h06;
    localparam logic [7:0] DAA_ADJ_HI = 8'h60;

    typedef struct packed {
        logic [5:0]  op;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic [3:0]  flags_in;
    } caf_cmd_t;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags_out;
    } caf_rsp_t;

    // Decode stage to execute stage.
    typedef struct packed {
        logic [5:0]  op;
        logic [15:0] a16;
        logic [7:0]  b8;
        logic [2:0]  bit_index;
        logic [3:0]  flags;
        logic [7:0]  x8;
        logic [7:0]  y8;
        logic        ci8;
        logic [15:0] x16;
        logic [15:0] y16;
        logic        ci16;
        logic        daa_c;
    } caf_dec_t;

    // Execute stage to result stage.
    typedef struct packed {
        logic [5:0]  op;
        logic [15:0] a16;
        logic [3:0]  flags;
        logic [7:0]  sum8;
        logic        c4_8;
        logic        c8_8;
        logic [15:0] sum16;
        logic        c4_16;
        logic        c8_16;
        logic        c12_16;
        logic        c16_16;
        logic [7:0]  aux8;
        logic        aux_c;
        logic        daa_c;
    } caf_exe_t;

endpackage
`default_nettype wire

// ===== rtl/core/caf_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// caf_decode: first pipeline stage
// Classifies the operation and sets up the operands and carry inputs of the
// 8-bit and 16-bit adders, including the decimal adjust correction.
// ----------------------------------------------------------------------------
module caf_decode
    import caf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire caf_cmd_t cmd,
    output logic          dec_valid,
    output caf_dec_t      dec
);

    logic     valid_reg;
    caf_dec_t dec_reg;
    caf_dec_t dec_next;

    logic [7:0] a8;
    logic [7:0] b8;
    logic       cin;
    logic       adj_hi;
    logic       adj_lo;
    logic [7:0] corr;

    assign a8  = cmd.operand_a[7:0];
    assign b8  = cmd.operand_b[7:0];
    assign cin = cmd.flags_in[FLAG_C];

    // Decimal adjust: after an addition the high correction also sets carry.
    always_comb
    begin
        if (cmd.flags_in[FLAG_N])
        begin
            adj_hi = cin;
            adj_lo = cmd.flags_in[FLAG_H];
        end
        else
        begin
            adj_hi = cin || (a8 > DAA_LIMIT);
            adj_lo = cmd.flags_in[FLAG_H] || (a8[3:0] > DAA_DIGIT);
        end
        corr = (adj_hi ? DAA_ADJ_HI : 8'h00) | (adj_lo ? DAA_ADJ_LO : 8'h00);
    end

    always_comb
    begin
        dec_next           = '0;
        dec_next.op        = cmd.op;
        dec_next.a16       = cmd.operand_a;
        dec_next.b8        = b8;
        dec_next.bit_index = cmd.bit_index;
        dec_next.flags     = cmd.flags_in;
        dec_next.daa_c     = adj_hi;
        dec_next.x8        = a8;
        dec_next.x16       = cmd.operand_a;

        // Subtractions add the complement; the carry out is an inverted borrow.
        case (cmd.op)
            OP_ADD:
            begin
                dec_next.y8  = b8;
                dec_next.ci8 = 1'b0;
            end
            OP_ADC:
            begin
                dec_next.y8  = b8;
                dec_next.ci8 = cin;
            end
            OP_SUB, OP_CP:
            begin
                dec_next.y8  = ~b8;
                dec_next.ci8 = 1'b1;
            end
            OP_SBC:
            begin
                dec_next.y8  = ~b8;
                dec_next.ci8 = ~cin;
            end
            OP_INC:
            begin
                dec_next.y8  = 8'h00;
                dec_next.ci8 = 1'b1;
            end
            OP_DEC:
            begin
                dec_next.y8  = 8'hFF;
                dec_next.ci8 = 1'b0;
            end
            OP_DAA:
            begin
                dec_next.y8  = cmd.flags_in[FLAG_N] ? ~corr : corr;
                dec_next.ci8 = cmd.flags_in[FLAG_N];
            end
            default:
            begin
                dec_next.y8  = 8'h00;
                dec_next.ci8 = 1'b0;
            end
        endcase

        case (cmd.op)
            OP_ADD16:
            begin
                dec_next.y16  = cmd.operand_b;
                dec_next.ci16 = 1'b0;
            end
            OP_ADDSP:
            begin
                dec_next.y16  = {{8{b8[7]}}, b8};
                dec_next.ci16 = 1'b0;
            end
            OP_INC16:
            begin
                dec_next.y16  = 16'h0000;
                dec_next.ci16 = 1'b1;
            end
            OP_DEC16:
            begin
                dec_next.y16  = 16'hFFFF;
                dec_next.ci16 = 1'b0;
            end
            default:
            begin
                dec_next.y16  = 16'h0000;
                dec_next.ci16 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

    assign dec_valid = valid_reg;
    assign dec       = dec_reg;

endmodule
`default_nettype wire

// ===== rtl/core/caf_exec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// caf_exec: second pipeline stage
// Runs the 8-bit and 16-bit adders and, in parallel, the logic, rotate,
// shift and bit operations on the low byte.
// ----------------------------------------------------------------------------
module caf_exec
    import caf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     dec_valid,
    input  wire caf_dec_t dec,
    output logic          exe_valid,
    output caf_exe_t      exe
);

    logic     valid_reg;
    caf_exe_t exe_reg;
    caf_exe_t exe_next;

    logic [8:0]  sum9;
    logic [7:0]  cv8;
    logic [16:0] sum17;
    logic [15:0] cv16;
    logic [7:0]  a8;
    logic [7:0]  mask;
    logic        cin;

    assign a8   = dec.a16[7:0];
    assign mask = 8'd1 << dec.bit_index;
    assign cin  = dec.flags[FLAG_C];

    // Carry into each bit is recovered as operand ^ operand ^ sum.
    assign sum9  = {1'b0, dec.x8} + {1'b0, dec.y8} + {8'd0, dec.ci8};
    assign cv8   = dec.x8 ^ dec.y8 ^ sum9[7:0];
    assign sum17 = {1'b0, dec.x16} + {1'b0, dec.y16} + {16'd0, dec.ci16};
    assign cv16  = dec.x16 ^ dec.y16 ^ sum17[15:0];

    always_comb
    begin
        exe_next        = '0;
        exe_next.op     = dec.op;
        exe_next.a16    = dec.a16;
        exe_next.flags  = dec.flags;
        exe_next.daa_c  = dec.daa_c;
        exe_next.sum8   = sum9[7:0];
        exe_next.c4_8   = cv8[4];
        exe_next.c8_8   = sum9[8];
        exe_next.sum16  = sum17[15:0];
        exe_next.c4_16  = cv16[4];
        exe_next.c8_16  = cv16[8];
        exe_next.c12_16 = cv16[12];
        exe_next.c16_16 = sum17[16];

        case (dec.op)
            OP_AND:
            begin
                exe_next.aux8  = a8 & dec.b8;
                exe_next.aux_c = 1'b0;
            end
            OP_XOR:
            begin
                exe_next.aux8  = a8 ^ dec.b8;
                exe_next.aux_c = 1'b0;
            end
            OP_OR:
            begin
                exe_next.aux8  = a8 | dec.b8;
                exe_next.aux_c = 1'b0;
            end
            OP_RLCA, OP_RLC:
            begin
                exe_next.aux8  = {a8[6:0], a8[7]};
                exe_next.aux_c = a8[7];
            end
            OP_RRCA, OP_RRC:
            begin
                exe_next.aux8  = {a8[0], a8[7:1]};
                exe_next.aux_c = a8[0];
            end
            OP_RLA, OP_RL:
            begin
                exe_next.aux8  = {a8[6:0], cin};
                exe_next.aux_c = a8[7];
            end
            OP_RRA, OP_RR:
            begin
                exe_next.aux8  = {cin, a8[7:1]};
                exe_next.aux_c = a8[0];
            end
            OP_SLA:
            begin
                exe_next.aux8  = {a8[6:0], 1'b0};
                exe_next.aux_c = a8[7];
            end
            OP_SRA:
            begin
                exe_next.aux8  = {a8[7], a8[7:1]};
                exe_next.aux_c = a8[0];
            end
            OP_SWAP:
            begin
                exe_next.aux8  = {a8[3:0], a8[7:4]};
                exe_next.aux_c = 1'b0;
            end
            OP_SRL:
            begin
                exe_next.aux8  = {1'b0, a8[7:1]};
                exe_next.aux_c = a8[0];
            end
            OP_CPL:
            begin
                exe_next.aux8  = ~a8;
                exe_next.aux_c = 1'b0;
            end
            OP_BIT:
            begin
                // The tested bit rides in aux_c.
                exe_next.aux8  = a8;
                exe_next.aux_c = |(a8 & mask);
            end
            OP_RES:
            begin
                exe_next.aux8  = a8 & ~mask;
                exe_next.aux_c = 1'b0;
            end
            OP_SET:
            begin
                exe_next.aux8  = a8 | mask;
                exe_next.aux_c = 1'b0;
            end
            default:
            begin
                exe_next.aux8  = a8;
                exe_next.aux_c = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= dec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        exe_reg <= exe_next;
    end

    assign exe_valid = valid_reg;
    assign exe       = exe_reg;

endmodule
`default_nettype wire

// ===== rtl/core/cpu_alu_with_flags.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_alu_with_flags: 8/16-bit ALU with Z, N, H, C flags
// Three-stage pipelined ALU: decode, execute, then result and flag select.
// ----------------------------------------------------------------------------
// Usage:
// A command beat is taken on every rising edge where start is high and busy
// is low. The beat carries the operation code, both operands, the bit index
// for bit tests and bit writes, and the incoming flags.
// The pipeline never holds off, so busy stays low and a new command can be
// issued in every cycle: throughput is one beat per clock.
// Each command produces exactly one response beat. A command taken on an edge
// passes through the three registered stages in order and then has its
// response on rsp with done high. The three stages are the operand setup, the
// 8-bit and 16-bit adders with the shift and bit unit beside them, and the
// final result and flag select.
// The response is held for a single cycle only; the receiver has no way to
// stall it and must take it when done is high.
// Reset clears the valid bits of all stages, so no response appears until a
// command has been issued after reset. Payload registers are not reset.
// The block keeps no state between commands.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags
    import caf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire caf_cmd_t cmd,
    output logic          done,
    output caf_rsp_t      rsp
);

    logic     dec_valid;
    caf_dec_t dec;
    logic     exe_valid;
    caf_exe_t exe;

    logic     done_reg;
    caf_rsp_t rsp_reg;
    caf_rsp_t rsp_next;

    logic     z8;
    logic     zaux;
    logic [3:0] f;

    // Nothing in the pipeline can back up, so commands are always welcome.
    assign busy = 1'b0;

    caf_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .cmd       (cmd),
        .dec_valid (dec_valid),
        .dec       (dec)
    );

    caf_exec u_exec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec       (dec),
        .exe_valid (exe_valid),
        .exe       (exe)
    );

    assign z8   = (exe.sum8 == 8'h00);
    assign zaux = (exe.aux8 == 8'h00);
    assign f    = exe.flags;

    // Result and flag select. Byte results are zero-extended to 16 bits.
    // For subtractions the adder carries are inverted borrows.
    always_comb
    begin
        rsp_next.result    = exe.a16;
        rsp_next.flags_out = f;
        case (exe.op)
            OP_ADD, OP_ADC:
            begin
                rsp_next.result    = {8'h00, exe.sum8};
                rsp_next.flags_out = {z8, 1'b0, exe.c4_8, exe.c8_8};
            end
            OP_SUB, OP_SBC:
            begin
                rsp_next.result    = {8'h00, exe.sum8};
                rsp_next.flags_out = {z8, 1'b1, ~exe.c4_8, ~exe.c8_8};
            end
            OP_CP:
            begin
                // Compare keeps the accumulator and only sets the flags.
                rsp_next.result    = {8'h00, exe.aux8};
                rsp_next.flags_out = {z8, 1'b1, ~exe.c4_8, ~exe.c8_8};
            end
            OP_AND:
            begin
                rsp_next.result    = {8'h00, exe.aux8};
                rsp_next.flags_out = {zaux, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR, OP_OR:
            begin
                rsp_next.result    = {8'h00, exe.aux8};
                rsp_next.flags_out = {zaux, 1'b0, 1'b0, 1'b0};
            end
            OP_INC:
            begin
                rsp_next.result    = {8'h00, exe.sum8};
                rsp_next.flags_out = {z8, 1'b0, exe.c4_8, f[FLAG_C]};
            end
            OP_DEC:
            begin
                rsp_next.result    = {8'h00, exe.sum8};
                rsp_next.flags_out = {z8, 1'b1, ~exe.c4_8, f[FLAG_C]};
            end
            OP_RLCA, OP_RRCA, OP_RLA, OP_RRA:
            begin
                // The accumulator rotates always clear Z.
                rsp_next.result    = {8'h00, exe.aux8};
                rsp_next.flags_out = {1'b0, 1'b0, 1'b0, exe.aux_c};
            end
            OP_DAA:
            begin
                rsp_next.result    = {8'h00, exe.sum8};
                rsp_next.flags_out = {z8, f[FLAG_N], 1'b0, exe.daa_c};
            end
            OP_CPL:
            begin
                rsp_next.result    = {8'h00, exe.aux8};
                rsp_next.flags_out = {f[FLAG_Z], 1'b1, 1'b1, f[FLAG_C]};
            end
            OP_SCF:
            begin
                rsp_next.result    = {8'h00, exe.aux8};
                rsp_next.flags_out = {f[FLAG_Z], 1'b0, 1'b0, 1'b1};
            end
            OP_CCF:
            begin
                rsp_next.result    = {8'h00, exe.aux8};
                rsp_next.flags_out = {f[FLAG_Z], 1'b0, 1'b0, ~f[FLAG_C]};
            end
            OP_BIT:
            begin
                rsp_next.result    = {8'h00, exe.aux8};
                rsp_next.flags_out = {~exe.aux_c, 1'b0, 1'b1, f[FLAG_C]};
            end
            OP_RES, OP_SET:
            begin
                rsp_next.result    = {8'h00, exe.aux8};
                rsp_next.flags_out = f;
            end
            OP_ADD16:
            begin
                rsp_next.result    = exe.sum16;
                rsp_next.flags_out = {f[FLAG_Z], 1'b0, exe.c12_16, exe.c16_16};
            end
            OP_ADDSP:
            begin
                // Half carry and carry come from the low byte of the sum.
                rsp_next.result    = exe.sum16;
                rsp_next.flags_out = {1'b0, 1'b0, exe.c4_16, exe.c8_16};
            end
            OP_INC16, OP_DEC16:
            begin
                rsp_next.result    = exe.sum16;
                rsp_next.flags_out = f;
            end
            default:
            begin
                if (exe.op inside {[OP_RLC:OP_SRL]})
                begin
                    rsp_next.result    = {8'h00, exe.aux8};
                    rsp_next.flags_out = {zaux, 1'b0, 1'b0, exe.aux_c};
                end
                else
                begin
                    // Unused codes pass the operand and flags through.
                    rsp_next.result    = exe.a16;
                    rsp_next.flags_out = f;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= exe_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
`default_nettype wire
